### design/tidal_turbine_power_curve_top_macros.svh
// Assertion macros used by the checker file.
`ifndef TIDAL_TURBINE_POWER_CURVE_TOP_MACROS_SVH
`define TIDAL_TURBINE_POWER_CURVE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TTPC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ttpc assertion failed");

// Next-cycle implication, disabled during reset.
`define TTPC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ttpc assertion failed");

// Next-cycle implication that also holds across reset.
`define TTPC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("ttpc assertion failed");

`endif

### design/ttpc_pkg.sv
// Shared types and constants of the tidal turbine power curve block.
package ttpc_pkg;

   localparam logic [1:0] MODE_CUBIC = 2'd0;
   localparam logic [1:0] MODE_EXP   = 2'd1;

   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_SPEED = 2'd1;
   localparam logic [1:0] CSR_CAP   = 2'd2;

   localparam int VEL_W   = 15;
   localparam int SPEED_W = 14;
   localparam int CAP_W   = 16;
   localparam int POWER_W = 24;
   localparam int FRAC_W  = 17;
   localparam int QUO_W   = 17;
   localparam int DEN_W   = 42;
   localparam int NUM_W   = 59;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

   typedef struct packed {
      logic zero;
      logic full;
      logic is_exp;
   } side_type;

endpackage

### design/tidal_turbine_power_curve_top.sv
// The pipe is 27 stages deep, 17 of them the quotient pipeline.
// Throughput: one request per cycle while no result is parked in the skid register.
// A result stall parks one result in the output skid register; the pipe halts next cycle.
// Reset (synchronous) clears all valid bits and loads mode 0, speed 2048, capacity 0.
// The curve table is constant logic and needs no fill after reset.
module tidal_turbine_power_curve_top import ttpc_pkg::*; #(
   parameter int EXP_TABLE_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [VEL_W-1:0]  req_current_speed,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [POWER_W-1:0]       rsp_power_out,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CAP_W-1:0]         csr_data
);

   logic [1:0]            mode_ff;
   logic [SPEED_W-1:0]    speed_ff;
   logic [CAP_W-1:0]      cap_ff;

   logic                  adv;
   logic                  fe_vld, dv_vld, ip_vld;
   logic [NUM_W-1:0]      fe_num;
   logic [DEN_W-1:0]      fe_den;
   side_type              fe_side, dv_side, ip_side;
   logic [QUO_W-1:0]      dv_quo, ip_quo;
   logic [FRAC_W-1:0]     ip_frac;

   logic                  vld5_ff, rsp_valid_ff;
   logic [FRAC_W-1:0]     f5_ff, f5_in;
   logic [POWER_W-1:0]    pwr_ff;
   logic [31:0]           prod;
   logic                  skid_vld_ff;
   logic [POWER_W-1:0]    skid_pwr_ff;

   // Advance the whole pipe unless a result is parked in the skid register.
   assign adv       = !skid_vld_ff;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_CUBIC;
         speed_ff <= 14'd2048;
         cap_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODE:  mode_ff  <= csr_data[1:0];
            CSR_SPEED: speed_ff <= csr_data[SPEED_W-1:0];
            CSR_CAP:   cap_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   ttpc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .adv               (adv),
      .req_valid         (req_valid),
      .req_current_speed (req_current_speed),
      .mode              (mode_ff),
      .design_speed      (speed_ff),
      .valid_o           (fe_vld),
      .num_o             (fe_num),
      .den_o             (fe_den),
      .side_o            (fe_side)
   );

   ttpc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .valid_i (fe_vld),
      .num_i   (fe_num),
      .den_i   (fe_den),
      .side_i  (fe_side),
      .valid_o (dv_vld),
      .quo_o   (dv_quo),
      .side_o  (dv_side)
   );

   ttpc_interp #(.DEPTH(EXP_TABLE_DEPTH)) u_interp (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .valid_i (dv_vld),
      .quo_i   (dv_quo),
      .side_i  (dv_side),
      .valid_o (ip_vld),
      .frac_o  (ip_frac),
      .quo_o   (ip_quo),
      .side_o  (ip_side)
   );

   always_comb begin
      if (ip_side.zero)
         f5_in = '0;
      else if (ip_side.full)
         f5_in = FRAC_ONE;
      else if (ip_side.is_exp)
         f5_in = ip_frac;
      else
         f5_in = ip_quo;
      prod = 32'(cap_ff) * 32'(f5_ff) + 32'd128;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld5_ff      <= ip_vld;
         rsp_valid_ff <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f5_ff  <= f5_in;
         pwr_ff <= prod[31:8];
      end
   end

   // Park the last-stage result when the consumer stalls; drop it once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (!skid_vld_ff) begin
         skid_vld_ff <= rsp_valid_ff && !rsp_ready;
      end else if (rsp_ready) begin
         skid_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_pwr_ff <= pwr_ff;
      end
   end

   assign rsp_valid     = skid_vld_ff || rsp_valid_ff;
   assign rsp_power_out = skid_vld_ff ? skid_pwr_ff : pwr_ff;

endmodule

### design/ttpc_front.sv
// Front end: range checks, cubes and divider operand set-up.
module ttpc_front import ttpc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      req_valid,
   input  logic signed [VEL_W-1:0]   req_current_speed,
   input  logic [1:0]                mode,
   input  logic [SPEED_W-1:0]        design_speed,
   output logic                      valid_o,
   output logic [NUM_W-1:0]          num_o,
   output logic [DEN_W-1:0]          den_o,
   output side_type                  side_o
);

   logic                     vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic signed [VEL_W-1:0]  v1_ff;
   logic [SPEED_W-1:0]       vm2_ff, d2_ff, dmv2_ff, dmv3_ff, d3s_ff;
   logic [2*SPEED_W-1:0]     vv2_ff, dd2_ff;
   logic [DEN_W-1:0]         v3_ff, d3_ff;
   side_type                 side2_ff, side3_ff, side4_ff;
   logic [NUM_W-1:0]         num4_ff;
   logic [DEN_W-1:0]         den4_ff;

   logic                     vpos;
   logic [SPEED_W-1:0]       vm;
   logic [22:0]              v20, d3x, v4, d5, v100, d29, d165;
   logic                     cub_out, exp_out;
   side_type                 side2_in;
   logic [NUM_W-1:0]         num4_in;
   logic [DEN_W-1:0]         den4_in;

   always_comb begin
      vpos = !v1_ff[VEL_W-1] && (|v1_ff[VEL_W-2:0]);
      vm   = v1_ff[SPEED_W-1:0];
      v20  = 23'(vm) * 23'd20;
      d3x  = 23'(design_speed) * 23'd3;
      v4   = 23'(vm) * 23'd4;
      d5   = 23'(design_speed) * 23'd5;
      v100 = 23'(vm) * 23'd100;
      d29  = 23'(design_speed) * 23'd29;
      d165 = 23'(design_speed) * 23'd165;
      cub_out = (v20 < d3x) || (v4 > d5);
      exp_out = (v100 < d29) || (v100 > d165);
      side2_in.is_exp = (mode == MODE_EXP);
      side2_in.full   = (vm > design_speed);
      side2_in.zero   = !vpos
                        || ((mode != MODE_CUBIC) && (mode != MODE_EXP))
                        || ((mode == MODE_CUBIC) && cub_out)
                        || ((mode == MODE_EXP) && exp_out);
   end

   always_comb begin
      if (side3_ff.is_exp) begin
         num4_in = {{(NUM_W-SPEED_W-16){1'b0}}, dmv3_ff, 16'h0000};
         den4_in = DEN_W'(d3s_ff);
      end else begin
         num4_in = {1'b0, v3_ff, 16'h0000} + NUM_W'(d3_ff >> 1);
         den4_in = d3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= req_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v1_ff    <= req_current_speed;
         vm2_ff   <= vm;
         d2_ff    <= design_speed;
         vv2_ff   <= (2*SPEED_W)'(vm) * (2*SPEED_W)'(vm);
         dd2_ff   <= (2*SPEED_W)'(design_speed) * (2*SPEED_W)'(design_speed);
         dmv2_ff  <= design_speed - vm;
         side2_ff <= side2_in;
         v3_ff    <= DEN_W'(vv2_ff) * DEN_W'(vm2_ff);
         d3_ff    <= DEN_W'(dd2_ff) * DEN_W'(d2_ff);
         dmv3_ff  <= dmv2_ff;
         d3s_ff   <= d2_ff;
         side3_ff <= side2_ff;
         num4_ff  <= num4_in;
         den4_ff  <= den4_in;
         side4_ff <= side3_ff;
      end
   end

   assign valid_o = vld4_ff;
   assign num_o   = num4_ff;
   assign den_o   = den4_ff;
   assign side_o  = side4_ff;

endmodule

### design/ttpc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ttpc_div import ttpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               valid_i,
   input  logic [NUM_W-1:0]   num_i,
   input  logic [DEN_W-1:0]   den_i,
   input  side_type           side_i,
   output logic               valid_o,
   output logic [QUO_W-1:0]   quo_o,
   output side_type           side_o
);

   logic               vld_ff  [QUO_W];
   logic [NUM_W-1:0]   rem_ff  [QUO_W];
   logic [DEN_W-1:0]   den_ff  [QUO_W];
   logic [QUO_W-1:0]   quo_ff  [QUO_W];
   side_type           side_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic               vld_prev;
      logic [NUM_W-1:0]   rem_prev, sub_d;
      logic [DEN_W-1:0]   den_prev;
      logic [QUO_W-1:0]   quo_prev;
      side_type           side_prev;
      logic               take;

      if (s == 0) begin : g_first
         assign vld_prev  = valid_i;
         assign rem_prev  = num_i;
         assign den_prev  = den_i;
         assign quo_prev  = '0;
         assign side_prev = side_i;
      end else begin : g_next
         assign vld_prev  = vld_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign quo_prev  = quo_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      // Trial-subtract the divisor aligned to this quotient bit.
      assign sub_d = NUM_W'(den_prev) << (QUO_W - 1 - s);
      assign take  = (rem_prev >= sub_d);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= take ? (rem_prev - sub_d) : rem_prev;
            den_ff[s]  <= den_prev;
            quo_ff[s]  <= {quo_prev[QUO_W-2:0], take};
            side_ff[s] <= side_prev;
         end
      end
   end

   assign valid_o = vld_ff[QUO_W-1];
   assign quo_o   = quo_ff[QUO_W-1];
   assign side_o  = side_ff[QUO_W-1];

endmodule

### design/ttpc_interp.sv
// Exponential curve: table lookup with linear interpolation.
module ttpc_interp import ttpc_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               valid_i,
   input  logic [QUO_W-1:0]   quo_i,
   input  side_type           side_i,
   output logic               valid_o,
   output logic [FRAC_W-1:0]  frac_o,
   output logic [QUO_W-1:0]   quo_o,
   output side_type           side_o
);

   localparam int PTR_W = $clog2(DEPTH + 1);
   localparam int P_W   = 16 + PTR_W;

   // Long division for the table build at elaboration.
   function automatic longint unsigned udiv(input longint unsigned a,
                                            input longint unsigned b);
      longint unsigned q, r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r    = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic signed [17:0] exp_point(input int k);
      longint unsigned den, x, term, ex, em;
      longint num, q;
      den  = 64'd100000 * 64'(DEPTH);
      x    = udiv(((64'd125909 * 64'(k)) << 30) + den / 2, den);
      term = 64'd1 << 30;
      ex   = term;
      for (int n = 1; n <= 24; n++) begin
         term = udiv(term * x, 64'(n) << 30);
         ex   = ex + term;
      end
      em  = udiv((64'd1 << 60) + ex / 2, ex);
      num = 64'sd169215 * longint'(em) - 64'sd69215 * (64'sd1 <<< 30);
      if (num >= 0)
         q = (num + 64'sd819200000) / 64'sd1638400000;
      else
         q = -((-num + 64'sd819200000) / 64'sd1638400000);
      return q[17:0];
   endfunction

   logic signed [17:0] tab [DEPTH+1];

   for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
      localparam logic signed [17:0] POINT = exp_point(k);
      assign tab[k] = POINT;
   end

   logic                      vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic [PTR_W-1:0]          idx1_ff;
   logic [15:0]               w1_ff, w2_ff;
   logic signed [17:0]        t0_ff, t1_ff;
   logic signed [35:0]        m0_ff, m1_ff;
   logic [FRAC_W-1:0]         f4_ff;
   logic [QUO_W-1:0]          q1_ff, q2_ff, q3_ff, q4_ff;
   side_type                  s1_ff, s2_ff, s3_ff, s4_ff;

   logic [P_W-1:0]            p;
   logic [PTR_W-1:0]          idx_raw, idx1_in, idx_nx;
   logic signed [36:0]        acc;
   logic [36:0]               acc_rnd;
   logic [FRAC_W-1:0]         f4_in;

   always_comb begin
      p       = P_W'(quo_i[15:0]) * P_W'(DEPTH);
      idx_raw = p[P_W-1:16];
      idx1_in = (idx_raw >= PTR_W'(DEPTH)) ? PTR_W'(DEPTH - 1) : idx_raw;
      idx_nx  = idx1_ff + PTR_W'(1);
   end

   always_comb begin
      acc     = 37'(m0_ff) + 37'(m1_ff);
      acc_rnd = 37'(acc) + 37'd32768;
      // Negative results round toward at most zero, so clamp them straight to zero.
      if (acc[36])
         f4_in = '0;
      else if (acc_rnd[36:16] > 21'(FRAC_ONE))
         f4_in = FRAC_ONE;
      else
         f4_in = acc_rnd[16 +: FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= valid_i;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx1_ff <= idx1_in;
         w1_ff   <= p[15:0];
         q1_ff   <= quo_i;
         s1_ff   <= side_i;
         t0_ff   <= tab[idx1_ff];
         t1_ff   <= tab[idx_nx];
         w2_ff   <= w1_ff;
         q2_ff   <= q1_ff;
         s2_ff   <= s1_ff;
         m0_ff   <= t0_ff * $signed({1'b0, FRAC_ONE - 17'(w2_ff)});
         m1_ff   <= t1_ff * $signed({2'b00, w2_ff});
         q3_ff   <= q2_ff;
         s3_ff   <= s2_ff;
         f4_ff   <= f4_in;
         q4_ff   <= q3_ff;
         s4_ff   <= s3_ff;
      end
   end

   assign valid_o = vld4_ff;
   assign frac_o  = f4_ff;
   assign quo_o   = q4_ff;
   assign side_o  = s4_ff;

endmodule

### design/ttpc_checker.sv
// Port-level checker for the power curve block, bound to the top level.
`include "tidal_turbine_power_curve_top_macros.svh"

module ttpc_checker import ttpc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [POWER_W-1:0]  rsp_power_out
);

   // A held result keeps its value.
   `TTPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_power_out))

   // A held result blocks new requests from the next cycle on.
   `TTPC_ASSERT_NEXT(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready)

   // Reset empties the pipe.
   `TTPC_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

   // No result appears right after an idle reset release with no request.
   `TTPC_ASSERT_NEXT_ALWAYS(a_no_early, reset && !req_valid, !rsp_valid)

endmodule

bind tidal_turbine_power_curve_top ttpc_checker u_ttpc_checker (.*);

### tb/tb_top.sv
// Testbench for the tidal turbine power curve block: predicted power per request vs results.
module tb_top;
   import ttpc_pkg::*;

   localparam int TAB_DEPTH = 64;
   localparam logic [1:0] MODE_NONE  = 2'd2;
   localparam logic [1:0] MODE_UNDEF = 2'd3;
   localparam int DRAIN_CYCLES = 40;

   class power_scoreboard;
      longint exp_tab[0:TAB_DEPTH];
      logic [1:0] mode;
      logic [SPEED_W-1:0] rated_speed;
      logic [CAP_W-1:0] capacity;
      logic [POWER_W-1:0] power_due[$];
      int errors;

      function new();
         longint unsigned den, x, term, ex, em;
         longint num;
         errors = 0;
         mode = MODE_CUBIC;
         rated_speed = 14'd2048;
         capacity = '0;
         den = 64'd100000 * TAB_DEPTH;
         for (int k = 0; k <= TAB_DEPTH; k++) begin
            x = (((64'd125909 * k) << 30) + den / 2) / den;
            term = 64'd1 << 30;
            ex = term;
            for (int n = 1; n <= 24; n++) begin
               term = (term * x) / (longint'(n) << 30);
               ex += term;
            end
            em = ((64'd1 << 60) + ex / 2) / ex;
            num = 169215 * longint'(em) - 69215 * (longint'(1) << 30);
            exp_tab[k] = round_div(num, 100000 * (longint'(1) << 14));
         end
      endfunction

      function longint round_div(longint num, longint den);
         if (num >= 0) return (num + den / 2) / den;
         return -((-num + den / 2) / den);
      endfunction

      function void set_reg(logic [1:0] idx, logic [CAP_W-1:0] data);
         case (idx)
            CSR_MODE:  mode = data[1:0];
            CSR_SPEED: rated_speed = data[SPEED_W-1:0];
            CSR_CAP:   capacity = data;
            default: ;
         endcase
      endfunction

      function logic [POWER_W-1:0] power_for(logic signed [VEL_W-1:0] speed);
         longint v, d, f, acc, w;
         longint unsigned v3, d3, u, p, idx;
         v = speed;
         d = rated_speed;
         f = 0;
         if (v > 0) begin
            if (mode == MODE_CUBIC) begin
               if (20 * v < 3 * d || 4 * v > 5 * d) f = 0;
               else if (v <= d) begin
                  v3 = v * v * v;
                  d3 = d * d * d;
                  f = ((v3 << 16) + d3 / 2) / d3;
               end else f = 65536;
            end else if (mode == MODE_EXP) begin
               if (100 * v < 29 * d || 100 * v > 165 * d) f = 0;
               else if (v <= d) begin
                  u = (longint'(d - v) << 16) / d;
                  p = u * TAB_DEPTH;
                  idx = p >> 16;
                  w = p & 64'hFFFF;
                  if (idx >= TAB_DEPTH) idx = TAB_DEPTH - 1;
                  acc = exp_tab[idx] * (65536 - w) + exp_tab[idx + 1] * w;
                  f = round_div(acc, 65536);
                  if (f < 0) f = 0;
                  if (f > 65536) f = 65536;
               end else f = 65536;
            end
         end
         return POWER_W'((longint'(capacity) * f + 128) >> 8);
      endfunction

      function void note_request(logic signed [VEL_W-1:0] speed);
         power_due.push_back(power_for(speed));
      endfunction

      function void check_result(logic [POWER_W-1:0] power);
         logic [POWER_W-1:0] want;
         if (power_due.size() == 0) begin
            $error("unexpected result: power_out %0d", power);
            errors++;
            return;
         end
         want = power_due.pop_front();
         if (power !== want) begin
            $error("power_out mismatch: expected %0d, actual %0d", want, power);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [VEL_W-1:0] req_current_speed = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [POWER_W-1:0] rsp_power_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [CAP_W-1:0] csr_data = '0;
   bit calm = 1'b0;
   power_scoreboard sb = new();

   tidal_turbine_power_curve_top u_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_power_out);
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
   end

   task automatic send_request(logic signed [VEL_W-1:0] speed);
      int gap;
      gap = (!calm && $urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_current_speed <= speed;
      do @(posedge clock); while (!req_ready);
      sb.note_request(speed);
   endtask

   // hold off until every result is back or the limit runs out, then let the pipeline settle
   task automatic drain(int limit);
      int n;
      req_valid <= 1'b0;
      n = 0;
      while (sb.power_due.size() != 0 && n < limit) begin
         @(posedge clock);
         n++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [CAP_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [1:0] mode, logic [CAP_W-1:0] spd, logic [CAP_W-1:0] cap);
      drain(100000);
      write_reg(CSR_MODE, {14'd0, mode});
      write_reg(CSR_SPEED, spd);
      write_reg(CSR_CAP, cap);
   endtask

   function automatic logic signed [VEL_W-1:0] pick_speed();
      int d;
      d = sb.rated_speed;
      if ($urandom_range(99) < 70 && d > 0) begin
         // mostly around the active span of the curve
         return VEL_W'($urandom_range(0, (2 * d < 16383) ? 2 * d : 16383));
      end
      return VEL_W'($urandom);
   endfunction

   task automatic random_requests(int count);
      repeat (count) send_request(pick_speed());
   endtask

   task automatic edge_requests();
      int d;
      d = sb.rated_speed;
      send_request(-15'sd16384);
      send_request(15'sd16383);
      send_request(15'sd0);
      send_request(15'sd1);
      send_request(-15'sd1);
      for (int k = -1; k <= 1; k++) begin
         send_request(VEL_W'((3 * d) / 20 + k));
         send_request(VEL_W'((29 * d) / 100 + k));
         send_request(VEL_W'(d + k));
         send_request(VEL_W'((5 * d) / 4 + k));
         send_request(VEL_W'((165 * d) / 100 + k));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset config: capacity zero
      random_requests(20);
      configure(MODE_CUBIC, 16'd2048, 16'd65535);
      edge_requests();
      random_requests(70);
      configure(MODE_EXP, 16'd2048, 16'd65535);
      edge_requests();
      random_requests(80);
      calm = 1'b1;
      configure(MODE_EXP, 16'd9000, 16'd1234);
      random_requests(80);
      calm = 1'b0;
      configure(MODE_CUBIC, 16'd16383, 16'hFFFF);
      edge_requests();
      random_requests(60);
      configure(MODE_EXP, 16'd1, 16'd40000);
      edge_requests();
      random_requests(30);
      configure(MODE_CUBIC, 16'd300, 16'd777);
      random_requests(60);
      configure(MODE_EXP, 16'd16383, 16'd65535);
      random_requests(60);
      configure(MODE_NONE, 16'd2048, 16'd65535);
      edge_requests();
      random_requests(30);
      configure(MODE_UNDEF, 16'd2048, 16'd65535);
      random_requests(30);
      configure(MODE_CUBIC, 16'd0, 16'd65535);
      random_requests(30);
      configure(MODE_EXP, 16'd0, 16'd500);
      random_requests(30);
      drain(100000);
      if (sb.power_due.size() != 0) begin
         $error("%0d results never arrived", sb.power_due.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILURE");
      $finish;
   end

endmodule
